@@ sv/pida_pkg.sv @@
// types and constants shared by the positional insert/delete array
package pida_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_READ   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cmd_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd_op                   op;
        logic signed [DATA_W-1:0]  value;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          wrap;
    } t_chain_cmd;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [DATA_W-1:0]  value;
        logic [CNT_W-1:0]          position;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic [1:0]                status;
        logic [CNT_W-1:0]          fill_count;
        logic                      last;
    } t_out;

endpackage

@@ sv/pida_cell.sv @@
// one storage cell of the shifting entry chain
module pida_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                               i_clk,
    input  pida_pkg::t_chain_cmd               i_cmd,
    input  logic signed [pida_pkg::DATA_W-1:0] i_left,
    input  logic signed [pida_pkg::DATA_W-1:0] i_right,
    input  logic signed [pida_pkg::DATA_W-1:0] i_head,
    output logic signed [pida_pkg::DATA_W-1:0] o_data
);

    localparam logic [pida_pkg::CNT_W-1:0] MY_IDX = pida_pkg::CNT_W'(CELL_IDX);

    logic signed [pida_pkg::DATA_W-1:0] r_data;
    logic signed [pida_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            pida_pkg::CMD_INSERT: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            pida_pkg::CMD_DELETE: begin
                if (MY_IDX >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            pida_pkg::CMD_ROTATE: begin
                if (MY_IDX == i_cmd.wrap) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ sv/positional_insert_delete_array.sv @@
// top level: ordered entry store built as a chain of shifting cells
// insert and delete: the status result is registered, valid in the cycle after acceptance
// read out: enters the read state, then one entry per cycle while the output register is free
// one transaction in work at a time; the single output register sets the pace
// reset clears the fill count, the controller and the output valid; cell contents are not reset
module positional_insert_delete_array #(
    parameter int DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pida_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pida_pkg::t_out o_out_data
);

    localparam logic [pida_pkg::CNT_W-1:0] DEPTH_C = pida_pkg::CNT_W'(DEPTH);

    pida_pkg::t_state     r_state, n_state;
    logic [pida_pkg::CNT_W-1:0] r_count, n_count;
    logic [pida_pkg::CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic                 r_out_valid, n_out_valid;
    pida_pkg::t_out       r_out, n_out;
    pida_pkg::t_chain_cmd w_cmd;
    logic                 w_slot_free;
    logic                 w_in_acc;
    logic                 w_rd_last;
    logic [pida_pkg::CNT_W:0] w_count_p1;

    logic signed [pida_pkg::DATA_W-1:0] w_cell [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [pida_pkg::DATA_W-1:0] w_left;
            logic signed [pida_pkg::DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[g+1];
            end
            pida_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_cell[0]),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == pida_pkg::ST_IDLE) && w_slot_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_count_p1  = {1'b0, r_count} + 1'b1;
    assign w_rd_last   = (r_rd_idx == r_count - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_cmd.op    = pida_pkg::CMD_NONE;
        w_cmd.value = i_in_data.value;
        w_cmd.pos   = i_in_data.position - 1'b1;
        w_cmd.wrap  = r_count - 1'b1;
        unique case (r_state)
            pida_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_out.data       = '0;
                    n_out.last       = 1'b1;
                    n_out.fill_count = r_count;
                    unique case (i_in_data.func)
                        pida_pkg::FN_INSERT: begin
                            n_out_valid = 1'b1;
                            if (i_in_data.position == '0 ||
                                {1'b0, i_in_data.position} > w_count_p1) begin
                                n_out.status = pida_pkg::STS_BADPOS;
                            end else if (r_count >= DEPTH_C) begin
                                n_out.status = pida_pkg::STS_FULL;
                            end else begin
                                n_out.status     = pida_pkg::STS_OK;
                                w_cmd.op         = pida_pkg::CMD_INSERT;
                                n_count          = r_count + 1'b1;
                                n_out.fill_count = r_count + 1'b1;
                            end
                        end
                        pida_pkg::FN_DELETE: begin
                            n_out_valid = 1'b1;
                            if (i_in_data.position == '0 || i_in_data.position > r_count) begin
                                n_out.status = pida_pkg::STS_BADPOS;
                            end else begin
                                n_out.status     = pida_pkg::STS_OK;
                                w_cmd.op         = pida_pkg::CMD_DELETE;
                                n_count          = r_count - 1'b1;
                                n_out.fill_count = r_count - 1'b1;
                            end
                        end
                        pida_pkg::FN_READ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = pida_pkg::STS_EMPTY;
                            end else begin
                                n_state  = pida_pkg::ST_READ;
                                n_rd_idx = '0;
                            end
                        end
                        default: begin
                            n_state = pida_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pida_pkg::ST_READ: begin
                if (w_slot_free) begin
                    n_out_valid      = 1'b1;
                    n_out.data       = w_cell[0];
                    n_out.status     = pida_pkg::STS_OK;
                    n_out.fill_count = r_count;
                    n_out.last       = w_rd_last;
                    w_cmd.op         = pida_pkg::CMD_ROTATE;
                    n_rd_idx         = r_rd_idx + 1'b1;
                    if (w_rd_last) begin
                        n_state = pida_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pida_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pida_pkg::ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count above depth");

    a_read_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pida_pkg::ST_READ |-> r_rd_idx < r_count)
        else $error("read index past fill count");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> r_state == pida_pkg::ST_READ)
        else $error("non-final result outside read out");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pida_pkg::ST_READ |=> r_count == $past(r_count))
        else $error("fill count changed during read out");

endmodule

@@ tb/positional_insert_delete_array_test.sv @@
// testbench for positional_insert_delete_array: checks insert, delete and read out against a shadow store
`timescale 1ns / 1ps

module positional_insert_delete_array_test;

    localparam int DEPTH = 64;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    pida_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    pida_pkg::t_out o_out_data;

    logic signed [pida_pkg::DATA_W-1:0] shadow_entries[$];
    pida_pkg::t_out array_op_results[$];
    int fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    positional_insert_delete_array #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("** positional_insert_delete_array: FAILED **");
        $finish;
    end

    // receiver side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result transaction check
    always @(posedge i_clk) begin
        pida_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (array_op_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: data %0d status %0d fill %0d last %0b",
                             o_out_data.data, o_out_data.status,
                             o_out_data.fill_count, o_out_data.last);
            end else begin
                want = array_op_results.pop_front();
                if (o_out_data.data !== want.data || o_out_data.status !== want.status ||
                    o_out_data.fill_count !== want.fill_count ||
                    o_out_data.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: exp data %0d status %0d fill %0d last %0b, %s",
                                 want.data, want.status, want.fill_count, want.last,
                                 $sformatf("got data %0d status %0d fill %0d last %0b",
                                           o_out_data.data, o_out_data.status,
                                           o_out_data.fill_count, o_out_data.last));
                end
            end
        end
    end

    function automatic void compute_array_op(input pida_pkg::t_in item);
        pida_pkg::t_out r;
        int pos;
        int held;
        pos  = int'(item.position);
        held = shadow_entries.size();
        r = '0;
        r.last = 1'b1;
        case (item.func)
            pida_pkg::FN_INSERT: begin
                if (pos == 0 || pos > held + 1) begin
                    r.status = pida_pkg::STS_BADPOS;
                end else if (held >= DEPTH) begin
                    r.status = pida_pkg::STS_FULL;
                end else begin
                    if (pos - 1 == held)
                        shadow_entries.push_back(item.value);
                    else
                        shadow_entries.insert(pos - 1, item.value);
                    r.status = pida_pkg::STS_OK;
                end
                r.fill_count = pida_pkg::CNT_W'(shadow_entries.size());
                array_op_results.push_back(r);
            end
            pida_pkg::FN_DELETE: begin
                if (pos == 0 || pos > held) begin
                    r.status = pida_pkg::STS_BADPOS;
                end else begin
                    shadow_entries.delete(pos - 1);
                    r.status = pida_pkg::STS_OK;
                end
                r.fill_count = pida_pkg::CNT_W'(shadow_entries.size());
                array_op_results.push_back(r);
            end
            pida_pkg::FN_READ: begin
                if (held == 0) begin
                    r.status = pida_pkg::STS_EMPTY;
                    array_op_results.push_back(r);
                end else begin
                    for (int i = 0; i < held; i++) begin
                        r.data       = shadow_entries[i];
                        r.status     = pida_pkg::STS_OK;
                        r.fill_count = pida_pkg::CNT_W'(held);
                        r.last       = (i == held - 1);
                        array_op_results.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int idle_cycles(input int unsigned pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 50)
            n++;
        return n;
    endfunction

    task automatic send_item(input pida_pkg::t_in item);
        int gap;
        gap = idle_cycles(send_idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        compute_array_op(item);
    endtask

    task automatic send_op(input logic [1:0] func,
                           input logic [pida_pkg::DATA_W-1:0] value,
                           input logic [pida_pkg::CNT_W-1:0] position);
        pida_pkg::t_in item;
        item.func     = func;
        item.value    = value;
        item.position = position;
        send_item(item);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (array_op_results.size() != 0);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(pida_pkg::FN_READ, 0, 0);
        send_op(pida_pkg::FN_DELETE, 0, 1);
        send_op(pida_pkg::FN_DELETE, 0, 0);
        send_op(pida_pkg::FN_INSERT, 5, 0);
        send_op(pida_pkg::FN_INSERT, 5, 2);
        send_op(pida_pkg::FN_INSERT, 32'h7fffffff, 1);
        send_op(pida_pkg::FN_INSERT, 32'h80000000, 1);
        send_op(pida_pkg::FN_INSERT, -1, 3);
        send_op(pida_pkg::FN_INSERT, 0, 2);
        send_op(pida_pkg::FN_INSERT, 32'h55555555, 5);
        send_op(pida_pkg::FN_INSERT, 32'haaaaaaaa, 3);
        send_op(pida_pkg::FN_INSERT, 1, 127);
        drain_results();
        send_op(pida_pkg::FN_READ, 32'hffffffff, 127);
        send_op(FN_UNUSED, 32'h12345678, 1);
        send_op(FN_UNUSED, 32'hffffffff, 127);
        send_op(pida_pkg::FN_DELETE, 0, 0);
        send_op(pida_pkg::FN_DELETE, 0, 7);
        send_op(pida_pkg::FN_DELETE, 0, 6);
        send_op(pida_pkg::FN_DELETE, 0, 1);
        send_op(pida_pkg::FN_DELETE, 32'hffffffff, 2);
        send_op(pida_pkg::FN_READ, 0, 0);
    endtask

    task automatic test_full_store();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        while (shadow_entries.size() < DEPTH)
            send_op(pida_pkg::FN_INSERT, $urandom(),
                    pida_pkg::CNT_W'($urandom_range(shadow_entries.size() + 1, 1)));
        send_op(pida_pkg::FN_READ, 0, 0);
        send_op(pida_pkg::FN_INSERT, 32'h0badf00d, 65);
        send_op(pida_pkg::FN_INSERT, 7, 66);
        send_op(pida_pkg::FN_INSERT, 7, 1);
        send_op(pida_pkg::FN_DELETE, 0, 64);
        send_op(pida_pkg::FN_INSERT, 32'h7fffffff, 64);
        send_op(pida_pkg::FN_DELETE, 0, 65);
        send_op(pida_pkg::FN_READ, 0, 0);
        while (shadow_entries.size() > 24)
            send_op(pida_pkg::FN_DELETE, 0,
                    pida_pkg::CNT_W'($urandom_range(shadow_entries.size(), 1)));
    endtask

    task automatic test_random_ops(input int unsigned count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
        int unsigned held;
        int unsigned pick;
        int unsigned ins_limit;
        pida_pkg::t_in item;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            held = shadow_entries.size();
            // keep the fill level drifting around the upper half
            ins_limit = (held > 40) ? 35 : 50;
            pick = $urandom_range(99);
            item.func     = pida_pkg::FN_READ;
            item.value    = $urandom();
            item.position = pida_pkg::CNT_W'($urandom_range(127, 0));
            if (pick < ins_limit) begin
                item.func     = pida_pkg::FN_INSERT;
                item.position = pida_pkg::CNT_W'($urandom_range(held + 1, 1));
            end else if (pick < 78 && held != 0) begin
                item.func     = pida_pkg::FN_DELETE;
                item.position = pida_pkg::CNT_W'($urandom_range(held, 1));
            end else if (pick >= 90) begin
                item.func = 2'($urandom_range(3, 0));
            end
            if ($urandom_range(29) == 0)
                drain_results();
            send_item(item);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_ops(70, 0, 0);
        test_full_store();
        test_random_ops(70, 57, 0);
        test_random_ops(70, 0, 57);
        test_random_ops(70, 35, 35);
        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("** positional_insert_delete_array: PASSED **");
        else
            $display("** positional_insert_delete_array: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pida_pkg.sv
sv/pida_cell.sv
sv/positional_insert_delete_array.sv
tb/positional_insert_delete_array_test.sv
